@@ hw/rtl/tower_sketch_conservative_update_defines.svh @@
// Assertion macros shared by the tower sketch RTL.
// Included by the controller and the datapath; no other dependencies.
`ifndef TOWER_SKETCH_CONSERVATIVE_UPDATE_DEFINES_SVH
`define TOWER_SKETCH_CONSERVATIVE_UPDATE_DEFINES_SVH

// Checked on every clock edge outside reset
`define TSCU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked on every clock edge, reset included
`define TSCU_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

@@ hw/rtl/tscu_pkg.sv @@
// Shared constants and controller/datapath interface types for the tower sketch.
// No dependencies.
package tscu_pkg;

    localparam int WORD_W            = 32;
    localparam int ROW_SLOTS         = 5;
    localparam int DEF_WORDS_PER_ROW = 1024;
    localparam int DEF_ROWS          = 5;
    // width of the per-row reciprocal used for the index reduction
    localparam int RECIP_W           = 34;

    // commands from the controller, one step of an item each
    typedef struct packed {
        logic clear;
        logic load;
        logic quot;
        logic rem;
        logic read;
        logic calc;
        logic write;
        logic out_load;
    } t_dp_cmd;

    // status back to the controller
    typedef struct packed {
        logic clr_last;
        logic op_query;
    } t_dp_status;

endpackage

@@ hw/rtl/tower_sketch_conservative_update.sv @@
// Channel    Dir  Handshake               Payload
// input      in   i_in_valid/o_in_stall   i_op, i_hash_row0..i_hash_row4
// result     out  o_out_valid/i_out_stall o_estimate, o_all_saturated
//
// Each item is accepted only once the previous one is done: two
// multiply steps reduce each row hash, then a registered RAM read, the
// minimum search and, for an insert, the write-back of the counter words.
// A query loads the result word in its last step; while an earlier result is
// still stalled, the block holds in that step.
// After reset a clearing pass over all WORDS_PER_ROW addresses zeroes all rows in
// parallel, with the input stalled; i_rst_n is synchronous, active low.
//
// Top level of the tower sketch; depends on tscu_pkg, tscu_ctrl, tscu_dp.
module tower_sketch_conservative_update
    import tscu_pkg::*;
#(
    parameter int WORDS_PER_ROW = DEF_WORDS_PER_ROW,
    parameter int ROWS          = DEF_ROWS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_op,
    input  logic [WORD_W-1:0] i_hash_row0,
    input  logic [WORD_W-1:0] i_hash_row1,
    input  logic [WORD_W-1:0] i_hash_row2,
    input  logic [WORD_W-1:0] i_hash_row3,
    input  logic [WORD_W-1:0] i_hash_row4,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [WORD_W-1:0] o_estimate,
    output logic              o_all_saturated
);

    t_dp_cmd           w_cmd;
    t_dp_status        w_status;
    logic [WORD_W-1:0] w_hash [ROW_SLOTS];

    assign w_hash[0] = i_hash_row0;
    assign w_hash[1] = i_hash_row1;
    assign w_hash[2] = i_hash_row2;
    assign w_hash[3] = i_hash_row3;
    assign w_hash[4] = i_hash_row4;

    tscu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    tscu_dp #(
        .WORDS_PER_ROW (WORDS_PER_ROW),
        .ROWS          (ROWS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_op            (i_op),
        .i_hash          (w_hash),
        .o_estimate      (o_estimate),
        .o_all_saturated (o_all_saturated)
    );

endmodule

@@ hw/rtl/tscu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on tscu_pkg for default sizes.
module tscu_ram
    import tscu_pkg::*;
#(
    parameter int WIDTH = WORD_W,
    parameter int DEPTH = DEF_WORDS_PER_ROW
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/tscu_ctrl.sv @@
// Sequencer for the tower sketch: clearing pass, item steps, output word valid.
// Depends on tscu_pkg and the assertion macro header.
`include "tower_sketch_conservative_update_defines.svh"

module tscu_ctrl
    import tscu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_status
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_QUOT,
        S_REM,
        S_READ,
        S_CALC,
        S_WRITE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // next state, commands and output valid
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_QUOT;
                end
            end
            S_QUOT: begin
                o_cmd.quot = 1'b1;
                n_state    = S_REM;
            end
            S_REM: begin
                o_cmd.rem = 1'b1;
                n_state   = S_READ;
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_CALC;
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_WRITE;
            end
            S_WRITE: begin
                // inserts write back; queries wait for a free output register
                if (!i_status.op_query) begin
                    o_cmd.write = 1'b1;
                    n_state     = S_IDLE;
                end else if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    `TSCU_ASSERT(a_out_load_free, o_cmd.out_load |-> (!r_out_valid || !i_out_stall), "output overwritten")
    `TSCU_ASSERT(a_valid_from_query, $rose(r_out_valid) |-> $past(r_state == S_WRITE && i_status.op_query), "result word without a query")
    `TSCU_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> (r_state == S_CLEAR && !r_out_valid), "reset did not start the clearing pass")

endmodule

@@ hw/rtl/tscu_dp.sv @@
// Datapath of the tower sketch: per-row index reduction, counter RAMs,
// minimum search, conservative increment and result register.
// Depends on tscu_pkg, tscu_ram and the assertion macro header.
`include "tower_sketch_conservative_update_defines.svh"

module tscu_dp
    import tscu_pkg::*;
#(
    parameter int WORDS_PER_ROW = DEF_WORDS_PER_ROW,
    parameter int ROWS          = DEF_ROWS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_status        o_status,
    input  logic              i_op,
    input  logic [WORD_W-1:0] i_hash [ROW_SLOTS],
    output logic [WORD_W-1:0] o_estimate,
    output logic              o_all_saturated
);

    localparam int AW = $clog2(WORDS_PER_ROW);

    logic              r_op;
    logic [AW-1:0]     r_clr_addr;
    logic [WORD_W-1:0] r_min, w_min;
    logic              r_any_live, w_any_live;
    logic [WORD_W-1:0] r_estimate;
    logic              r_all_saturated;

    logic [WORD_W-1:0] w_val  [ROWS];
    logic              w_live [ROWS];
    logic [WORD_W-1:0] r_val  [ROWS];
    logic              r_live [ROWS];
    logic              w_we     [ROWS];
    logic              w_idx_ok [ROWS];

    // clearing pass address, all rows in parallel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    assign o_status.clr_last = (r_clr_addr == AW'(WORDS_PER_ROW - 1));
    assign o_status.op_query = r_op;

    // one lane per row
    for (genvar r = 0; r < ROWS; r++) begin : g_lane
        localparam int                 SPAN_LOG = AW + r;
        localparam int                 RW       = SPAN_LOG + 1;
        localparam int                 RSH      = WORD_W + SPAN_LOG;
        localparam logic [63:0]        SPAN     = 64'(WORDS_PER_ROW) << r;
        localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'((64'd1 << RSH) / SPAN);
        localparam int                 CW_LOG   = 5 - r;
        localparam int                 SUB_W    = (r == 0) ? 1 : r;
        localparam logic [SUB_W-1:0]   SUB_MASK = SUB_W'((1 << r) - 1);
        localparam logic [WORD_W-1:0]  CTR_MAX  =
            WORD_W'(64'hFFFF_FFFF >> (WORD_W - (WORD_W >> r)));

        logic [WORD_W-1:0] r_hash;
        logic [WORD_W-1:0] r_quot;
        logic [RW-1:0]     r_rem;
        logic [AW-1:0]     r_addr;
        logic [SUB_W-1:0]  r_sub;
        logic [WORD_W-1:0] r_word;
        logic [65:0]       w_prod;
        logic [RW-1:0]     w_qspan;
        logic [RW-1:0]     w_idx;
        logic [AW-1:0]     w_addr;
        logic [SUB_W-1:0]  w_sub;
        logic [4:0]        w_sh;
        logic [WORD_W-1:0] w_rdata;
        logic [WORD_W-1:0] w_wdata;

        // hash mod span: reciprocal estimate, then one correction step
        assign w_prod  = 66'(r_hash) * 66'(RECIP);
        assign w_qspan = RW'(64'(r_quot) * SPAN);
        assign w_idx   = (r_rem >= SPAN[RW-1:0]) ? (r_rem - SPAN[RW-1:0]) : r_rem;
        assign w_addr  = AW'(w_idx >> r);
        assign w_sub   = SUB_W'(w_idx) & SUB_MASK;
        assign w_sh    = 5'(r_sub) << CW_LOG;

        assign w_idx_ok[r] = (w_idx < SPAN[RW-1:0]);

        always_ff @(posedge i_clk) begin
            if (i_cmd.load) begin
                r_hash <= i_hash[r];
            end
            if (i_cmd.quot) begin
                r_quot <= WORD_W'(w_prod >> RSH);
            end
            if (i_cmd.rem) begin
                r_rem <= r_hash[RW-1:0] - w_qspan;
            end
            if (i_cmd.read) begin
                r_addr <= w_addr;
                r_sub  <= w_sub;
            end
            if (i_cmd.calc) begin
                r_word <= w_rdata;
            end
        end

        // counter extraction from the read word
        assign w_val[r]  = (w_rdata >> w_sh) & CTR_MAX;
        assign w_live[r] = (w_val[r] != CTR_MAX);

        // conservative increment: only live counters at the minimum
        assign w_we[r]  = i_cmd.clear || (i_cmd.write && r_live[r] && (r_val[r] == r_min));
        assign w_wdata  = i_cmd.clear ? '0 : (r_word + (WORD_W'(1) << w_sh));

        tscu_ram #(
            .WIDTH (WORD_W),
            .DEPTH (WORDS_PER_ROW)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_we[r]),
            .i_waddr (i_cmd.clear ? r_clr_addr : r_addr),
            .i_wdata (w_wdata),
            .i_re    (i_cmd.read),
            .i_raddr (w_addr),
            .o_rdata (w_rdata)
        );
    end

    // minimum over live counters
    always_comb begin
        w_min      = '1;
        w_any_live = 1'b0;
        for (int r = 0; r < ROWS; r++) begin
            if (w_live[r] && (w_val[r] < w_min)) begin
                w_min = w_val[r];
            end
            w_any_live = w_any_live | w_live[r];
        end
    end

    // item op, per-row values, minimum and result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_op;
        end
        if (i_cmd.calc) begin
            r_min      <= w_min;
            r_any_live <= w_any_live;
            for (int r = 0; r < ROWS; r++) begin
                r_val[r]  <= w_val[r];
                r_live[r] <= w_live[r];
            end
        end
        if (i_cmd.out_load) begin
            r_estimate      <= r_min;
            r_all_saturated <= !r_any_live;
        end
    end

    assign o_estimate      = r_estimate;
    assign o_all_saturated = r_all_saturated;

    `TSCU_ASSERT(a_idx_in_range, i_cmd.read |-> (w_idx_ok.and()), "row index reduction out of range")
    `TSCU_ASSERT(a_we_cmd, (w_we.or()) |-> (i_cmd.clear || i_cmd.write), "counter write outside clear or update")

endmodule
